// ----- sv/reliable_receiver_reorder_window_macros.svh -----
// ----------------------------------------------------------------------------
// Reorder window receiver - assertion macros
// Shared property wrappers used by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_RECEIVER_REORDER_WINDOW_MACROS_SVH
`define RELIABLE_RECEIVER_REORDER_WINDOW_MACROS_SVH

// same-cycle implication, held off during reset
`define RRW_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rrw: same-cycle check failed");

// next-cycle implication, held off during reset
`define RRW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rrw: next-cycle check failed");

`endif

// ----- sv/rrw_pkg.sv -----
// ----------------------------------------------------------------------------
// rrw_pkg
// Types and constants of the reorder window receiver.
// ----------------------------------------------------------------------------
package rrw_pkg;

  localparam int unsigned SEQ_W  = 32;
  localparam int unsigned REF_W  = 16;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned SLOT_W = REF_W + LEN_W;

  localparam logic [SEQ_W-1:0] ISN_RESET = 32'd5000;

  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CTRL  = 2'd3;

  typedef enum logic [1:0] {
    KIND_DELIVER = 2'd0,
    KIND_SYNACK  = 2'd1,
    KIND_ACK     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_LISTEN = 2'd0,
    PH_WAIT   = 2'd1,
    PH_EST    = 2'd2,
    PH_CLOSED = 2'd3
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OWN,
    S_ACKN,
    S_EMIT,
    S_SETEXP,
    S_DIST,
    S_CLASS,
    S_DELIV,
    S_EXPINC,
    S_PEEK,
    S_DRN
  } state_e;

  // request to the shared adder
  typedef struct packed {
    logic [SEQ_W-1:0] a;
    logic [SEQ_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  own_seq;
    logic [SEQ_W-1:0]  ack_num;
    logic [REF_W-1:0]  out_ref;
    logic [LEN_W-1:0]  out_len;
    logic              last;
    logic              closed;
  } out_item_t;

endpackage

// ----- sv/rrw_if.sv -----
// ----------------------------------------------------------------------------
// rrw_if
// Valid/ready channels of the receiver: packet in, result out, config write.
// ----------------------------------------------------------------------------
interface rrw_in_if;
  logic                          valid;
  logic                          ready;
  logic [rrw_pkg::MODE_W-1:0]    mode;
  logic [rrw_pkg::SEQ_W-1:0]     seq_num;
  logic [rrw_pkg::REF_W-1:0]     payload_ref;
  logic [rrw_pkg::LEN_W-1:0]     payload_len;

  modport source (output valid, mode, seq_num, payload_ref, payload_len, input ready);
  modport sink   (input valid, mode, seq_num, payload_ref, payload_len, output ready);
endinterface

interface rrw_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrw_pkg::KIND_W-1:0]    kind;
  logic [rrw_pkg::SEQ_W-1:0]     own_seq;
  logic [rrw_pkg::SEQ_W-1:0]     ack_num;
  logic [rrw_pkg::REF_W-1:0]     out_ref;
  logic [rrw_pkg::LEN_W-1:0]     out_len;
  logic                          last;
  logic                          closed;

  modport source (output valid, kind, own_seq, ack_num, out_ref, out_len, last, closed,
                  input ready);
  modport sink   (input valid, kind, own_seq, ack_num, out_ref, out_len, last, closed,
                  output ready);
endinterface

interface rrw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rrw_pkg::SEQ_W-1:0]     data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- sv/rrw_alu.sv -----
// ----------------------------------------------------------------------------
// rrw_alu
// Shared 32-bit adder/subtractor for all sequence arithmetic.
// ----------------------------------------------------------------------------
module rrw_alu (
  input  rrw_pkg::alu_req_t          req_i,
  output logic [rrw_pkg::SEQ_W-1:0]  res_o
);

  // wraps modulo 2^32 like the sequence space
  assign res_o = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);

endmodule

// ----- sv/rrw_slots.sv -----
// ----------------------------------------------------------------------------
// rrw_slots
// Window buffer: payload memory with registered read, valid bits in flops.
// ----------------------------------------------------------------------------
module rrw_slots #(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned IDX_W  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_all_i,
  input  logic                         wr_en_i,
  input  logic [IDX_W-1:0]             wr_addr_i,
  input  logic [rrw_pkg::SLOT_W-1:0]   wr_data_i,
  input  logic                         rd_en_i,
  input  logic                         clr_en_i,
  input  logic [IDX_W-1:0]             head_i,
  output logic                         head_valid_o,
  output logic [rrw_pkg::SLOT_W-1:0]   rd_data_o
);

  logic [rrw_pkg::SLOT_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]          valid_q, valid_d;
  logic [rrw_pkg::SLOT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[head_i];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (clr_all_i) begin
      valid_d = '0;
    end else begin
      if (clr_en_i) valid_d[head_i] = 1'b0;
      if (wr_en_i)  valid_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign head_valid_o = valid_q[head_i];
  assign rd_data_o    = rd_data_q;

endmodule

// ----- sv/reliable_receiver_reorder_window.sv -----
// ----------------------------------------------------------------------------
// reliable_receiver_reorder_window
// Selective-repeat receiver: handshake, in-order delivery with drain of the
// reorder window, cumulative and single ACKs, FIN close.
// ----------------------------------------------------------------------------
//  port    dir   request
//  in_i    sink  one received packet (mode, seq_num, payload ref/len)
//  out_o   src   one result: deliver, SYN-ACK or ACK
//  cfg_i   sink  write of initial_sequence, always ready
//
// All sequence arithmetic shares one 32-bit adder. A packet is accepted only in
// idle, so the next packet waits until the current one is fully processed.
// Each emitting state also waits while the output register is held.
// Reset clears valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module reliable_receiver_reorder_window #(
  parameter int unsigned WINDOW = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrw_in_if.sink     in_i,
  rrw_out_if.source  out_o,
  rrw_cfg_if.sink    cfg_i
);

  `include "reliable_receiver_reorder_window_macros.svh"

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  rrw_pkg::state_e   state_q, state_d;
  rrw_pkg::phase_e   phase_q;

  logic [rrw_pkg::SEQ_W-1:0]  own_q, exp_q, ack_q, dist_q, seq_q;
  logic [rrw_pkg::MODE_W-1:0] mode_q;
  logic [rrw_pkg::REF_W-1:0]  ref_q;
  logic [rrw_pkg::LEN_W-1:0]  len_q;
  logic [IDX_W-1:0]           head_q, drn_cnt_q;
  logic                       ack_exp_q;

  logic                       out_valid_q;
  rrw_pkg::out_item_t         out_q, out_d;

  rrw_pkg::alu_req_t          alu_req;
  logic [rrw_pkg::SEQ_W-1:0]  alu_res;

  logic in_acc, out_free, load;
  logic slot_wr, slot_rd, slot_clr, slot_clr_all, head_valid;
  logic [rrw_pkg::SLOT_W-1:0] slot_rdata;
  logic [IDX_W:0]             idx_sum;
  logic [IDX_W-1:0]           wr_idx, head_nxt;
  logic dist_zero, dist_win, dist_stale, drn_more, is_fin;
  logic listen_acc, is_closed;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  assign dist_zero  = (dist_q == '0);
  assign dist_win   = (dist_q < rrw_pkg::SEQ_W'(WINDOW));
  assign dist_stale = dist_q[rrw_pkg::SEQ_W-1];
  assign drn_more   = head_valid && (drn_cnt_q < IDX_W'(WINDOW - 1));
  assign is_fin     = (phase_q == rrw_pkg::PH_EST) && (mode_q == rrw_pkg::MODE_FIN);
  assign listen_acc = in_acc && (phase_q == rrw_pkg::PH_LISTEN);
  assign is_closed  = (phase_q == rrw_pkg::PH_CLOSED);

  // slot for a packet ahead: (head + d) mod WINDOW, with d < WINDOW
  assign idx_sum = {1'b0, head_q} + {1'b0, dist_q[IDX_W-1:0]};
  assign wr_idx  = (idx_sum >= (IDX_W+1)'(WINDOW)) ?
                   IDX_W'(idx_sum - (IDX_W+1)'(WINDOW)) : idx_sum[IDX_W-1:0];
  assign head_nxt = (head_q == IDX_W'(WINDOW - 1)) ? '0 : head_q + IDX_W'(1);

  rrw_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  rrw_slots #(
    .WINDOW (WINDOW),
    .IDX_W  (IDX_W)
  ) u_slots (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clr_all_i    (slot_clr_all),
    .wr_en_i      (slot_wr),
    .wr_addr_i    (wr_idx),
    .wr_data_i    ({len_q, ref_q}),
    .rd_en_i      (slot_rd),
    .clr_en_i     (slot_clr),
    .head_i       (head_q),
    .head_valid_o (head_valid),
    .rd_data_o    (slot_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rrw_pkg::S_IDLE: begin
        if (in_acc) begin
          case (phase_q)
            rrw_pkg::PH_LISTEN: state_d = rrw_pkg::S_OWN;
            rrw_pkg::PH_WAIT:   state_d = rrw_pkg::S_SETEXP;
            rrw_pkg::PH_EST: begin
              if (in_i.mode == rrw_pkg::MODE_FIN)       state_d = rrw_pkg::S_OWN;
              else if (in_i.mode == rrw_pkg::MODE_DATA) state_d = rrw_pkg::S_DIST;
              else                                      state_d = rrw_pkg::S_IDLE;
            end
            default: state_d = rrw_pkg::S_IDLE;
          endcase
        end
      end
      rrw_pkg::S_OWN:    state_d = rrw_pkg::S_ACKN;
      rrw_pkg::S_ACKN:   state_d = rrw_pkg::S_EMIT;
      rrw_pkg::S_EMIT:   if (out_free) state_d = rrw_pkg::S_IDLE;
      rrw_pkg::S_SETEXP: state_d = rrw_pkg::S_IDLE;
      rrw_pkg::S_DIST:   state_d = rrw_pkg::S_CLASS;
      rrw_pkg::S_CLASS: begin
        if (dist_zero)                  state_d = rrw_pkg::S_DELIV;
        else if (dist_win || dist_stale) state_d = rrw_pkg::S_OWN;
        else                            state_d = rrw_pkg::S_IDLE;
      end
      rrw_pkg::S_DELIV:  if (out_free) state_d = rrw_pkg::S_EXPINC;
      rrw_pkg::S_EXPINC: state_d = rrw_pkg::S_PEEK;
      rrw_pkg::S_PEEK:   state_d = drn_more ? rrw_pkg::S_DRN : rrw_pkg::S_OWN;
      rrw_pkg::S_DRN:    if (out_free) state_d = rrw_pkg::S_EXPINC;
      default:           state_d = rrw_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready   = (state_q == rrw_pkg::S_IDLE);
    alu_req      = '{a: exp_q, b: rrw_pkg::SEQ_W'(1), sub: 1'b0};
    slot_wr      = 1'b0;
    slot_rd      = 1'b0;
    slot_clr     = 1'b0;
    slot_clr_all = 1'b0;
    load         = 1'b0;
    out_d        = '0;
    case (state_q)
      rrw_pkg::S_OWN:    alu_req = '{a: own_q, b: rrw_pkg::SEQ_W'(1), sub: 1'b0};
      rrw_pkg::S_ACKN: begin
        // cumulative ACK carries expected as is, others seq + 1
        if (ack_exp_q) begin
          alu_req = '{a: exp_q, b: '0, sub: 1'b0};
        end else begin
          alu_req = '{a: seq_q, b: rrw_pkg::SEQ_W'(1), sub: 1'b0};
        end
      end
      rrw_pkg::S_SETEXP: begin
        alu_req      = '{a: seq_q, b: rrw_pkg::SEQ_W'(1), sub: 1'b0};
        slot_clr_all = 1'b1;
      end
      rrw_pkg::S_DIST:   alu_req = '{a: seq_q, b: exp_q, sub: 1'b1};
      rrw_pkg::S_CLASS:  slot_wr = !dist_zero && dist_win;
      rrw_pkg::S_EMIT: begin
        load          = out_free;
        out_d.kind    = (phase_q == rrw_pkg::PH_LISTEN) ? rrw_pkg::KIND_SYNACK
                                                        : rrw_pkg::KIND_ACK;
        out_d.own_seq = own_q;
        out_d.ack_num = ack_q;
        out_d.last    = 1'b1;
        out_d.closed  = is_fin;
      end
      rrw_pkg::S_DELIV: begin
        load          = out_free;
        out_d.kind    = rrw_pkg::KIND_DELIVER;
        out_d.out_ref = ref_q;
        out_d.out_len = len_q;
      end
      rrw_pkg::S_EXPINC: alu_req = '{a: exp_q, b: rrw_pkg::SEQ_W'(1), sub: 1'b0};
      rrw_pkg::S_PEEK:   slot_rd = drn_more;
      rrw_pkg::S_DRN: begin
        load          = out_free;
        slot_clr      = out_free;
        out_d.kind    = rrw_pkg::KIND_DELIVER;
        out_d.out_ref = slot_rdata[rrw_pkg::REF_W-1:0];
        out_d.out_len = slot_rdata[rrw_pkg::SLOT_W-1:rrw_pkg::REF_W];
      end
      default: ;
    endcase
  end

  // control and sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrw_pkg::S_IDLE;
      phase_q     <= rrw_pkg::PH_LISTEN;
      own_q       <= rrw_pkg::ISN_RESET;
      exp_q       <= '0;
      head_q      <= '0;
      drn_cnt_q   <= '0;
      ack_exp_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && (phase_q == rrw_pkg::PH_LISTEN) && (state_q != rrw_pkg::S_OWN)) begin
        own_q <= cfg_i.data;
      end
      if (load)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      case (state_q)
        rrw_pkg::S_IDLE:   ack_exp_q <= 1'b0;
        rrw_pkg::S_OWN:    own_q <= alu_res;
        rrw_pkg::S_SETEXP: begin
          exp_q   <= alu_res;
          head_q  <= '0;
          phase_q <= rrw_pkg::PH_EST;
        end
        rrw_pkg::S_CLASS:  drn_cnt_q <= '0;
        rrw_pkg::S_EXPINC: begin
          exp_q  <= alu_res;
          head_q <= head_nxt;
        end
        rrw_pkg::S_PEEK:   if (!drn_more) ack_exp_q <= 1'b1;
        rrw_pkg::S_DRN:    if (out_free) drn_cnt_q <= drn_cnt_q + IDX_W'(1);
        rrw_pkg::S_EMIT: begin
          if (out_free) begin
            if (phase_q == rrw_pkg::PH_LISTEN) phase_q <= rrw_pkg::PH_WAIT;
            else if (is_fin)                   phase_q <= rrw_pkg::PH_CLOSED;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_i.mode;
      seq_q  <= in_i.seq_num;
      ref_q  <= in_i.payload_ref;
      len_q  <= in_i.payload_len;
    end
    if (state_q == rrw_pkg::S_ACKN) ack_q  <= alu_res;
    if (state_q == rrw_pkg::S_DIST) dist_q <= alu_res;
    if (load) out_q <= out_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.kind    = out_q.kind;
  assign out_o.own_seq = out_q.own_seq;
  assign out_o.ack_num = out_q.ack_num;
  assign out_o.out_ref = out_q.out_ref;
  assign out_o.out_len = out_q.out_len;
  assign out_o.last    = out_q.last;
  assign out_o.closed  = out_q.closed;

  `RRW_ASSERT_NEXT(a_closed_sticks, clk_i, rst_ni, is_closed, is_closed)
  `RRW_ASSERT_NOW(a_drain_bound, clk_i, rst_ni, 1'b1, drn_cnt_q <= IDX_W'(WINDOW - 1))
  `RRW_ASSERT_NOW(a_drain_valid, clk_i, rst_ni, state_q == rrw_pkg::S_DRN, head_valid)
  `RRW_ASSERT_NEXT(a_listen_to_own, clk_i, rst_ni, listen_acc, state_q == rrw_pkg::S_OWN)

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - reorder window receiver bench
// Drives packets, config writes and result back-pressure over the three
// valid/ready channels. A scoreboard predicts each result from the packets
// it has seen and checks every result against the oldest pending one.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WIN          = 16;
  localparam int unsigned SETTLE       = 64;   // worst in-order drain plus margin
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;

  class reorder_scoreboard;
    rrw_pkg::phase_e                link_phase;
    logic [rrw_pkg::SEQ_W-1:0]      isn_reg;
    logic [rrw_pkg::SEQ_W-1:0]      own_ctr;
    logic [rrw_pkg::SEQ_W-1:0]      next_seq;
    int unsigned                    head;
    bit                             slot_full[WIN];
    logic [rrw_pkg::SLOT_W-1:0]     slot_data[WIN];
    rrw_pkg::out_item_t             due_results[$];
    int                             errors;

    function new();
      link_phase = rrw_pkg::PH_LISTEN;
      isn_reg    = rrw_pkg::ISN_RESET;
      own_ctr    = rrw_pkg::ISN_RESET;
      next_seq   = '0;
      head       = 0;
      errors     = 0;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
    endfunction

    function void write_isn(logic [rrw_pkg::SEQ_W-1:0] v);
      isn_reg = v;
      if (link_phase == rrw_pkg::PH_LISTEN) own_ctr = v;
    endfunction

    function void queue_result(rrw_pkg::kind_e k, logic [rrw_pkg::SEQ_W-1:0] own,
                               logic [rrw_pkg::SEQ_W-1:0] ackn,
                               logic [rrw_pkg::REF_W-1:0] pref,
                               logic [rrw_pkg::LEN_W-1:0] plen, logic cl);
      rrw_pkg::out_item_t r;
      r.kind    = k;
      r.own_seq = own;
      r.ack_num = ackn;
      r.out_ref = pref;
      r.out_len = plen;
      r.last    = 1'b0;
      r.closed  = cl;
      due_results.push_back(r);
    endfunction

    function void queue_ack(logic [rrw_pkg::SEQ_W-1:0] ackn, logic cl);
      own_ctr = own_ctr + 1;
      queue_result(rrw_pkg::KIND_ACK, own_ctr, ackn, '0, '0, cl);
    endfunction

    function void take_packet(logic [rrw_pkg::MODE_W-1:0] mode,
                              logic [rrw_pkg::SEQ_W-1:0] seq,
                              logic [rrw_pkg::REF_W-1:0] pref,
                              logic [rrw_pkg::LEN_W-1:0] plen);
      int                         first;
      int                         n;
      int unsigned                idx;
      logic [rrw_pkg::SEQ_W-1:0]  ahead;
      first = due_results.size();
      case (link_phase)
        rrw_pkg::PH_LISTEN: begin
          own_ctr = own_ctr + 1;
          queue_result(rrw_pkg::KIND_SYNACK, own_ctr, seq + 1, '0, '0, 1'b0);
          link_phase = rrw_pkg::PH_WAIT;
        end
        rrw_pkg::PH_WAIT: begin
          next_seq = seq + 1;
          head     = 0;
          foreach (slot_full[i]) slot_full[i] = 1'b0;
          link_phase = rrw_pkg::PH_EST;
        end
        rrw_pkg::PH_EST: begin
          if (mode == rrw_pkg::MODE_FIN) begin
            queue_ack(seq + 1, 1'b1);
            link_phase = rrw_pkg::PH_CLOSED;
          end else if (mode == rrw_pkg::MODE_DATA) begin
            ahead = seq - next_seq;
            if (ahead == 0) begin
              queue_result(rrw_pkg::KIND_DELIVER, '0, '0, pref, plen, 1'b0);
              next_seq = next_seq + 1;
              head     = (head + 1) % WIN;
              for (n = 0; n < WIN - 1 && slot_full[head]; n++) begin
                queue_result(rrw_pkg::KIND_DELIVER, '0, '0,
                             slot_data[head][rrw_pkg::REF_W-1:0],
                             slot_data[head][rrw_pkg::SLOT_W-1:rrw_pkg::REF_W], 1'b0);
                slot_full[head] = 1'b0;
                next_seq = next_seq + 1;
                head     = (head + 1) % WIN;
              end
              queue_ack(next_seq, 1'b0);
            end else if (ahead < WIN) begin
              idx            = (head + ahead) % WIN;
              slot_full[idx] = 1'b1;
              slot_data[idx] = {plen, pref};
              queue_ack(seq + 1, 1'b0);
            end else if (ahead[rrw_pkg::SEQ_W-1]) begin
              // stale: behind expected
              queue_ack(seq + 1, 1'b0);
            end
          end
        end
        default: ;
      endcase
      if (due_results.size() > first) due_results[$].last = 1'b1;
    endfunction

    function void check_field(string name, logic [rrw_pkg::SEQ_W-1:0] want,
                              logic [rrw_pkg::SEQ_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rrw_pkg::out_item_t got);
      rrw_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d own_seq %0h ack_num %0h",
               got.kind, got.own_seq, got.ack_num);
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("kind",    want.kind,    got.kind);
      check_field("own_seq", want.own_seq, got.own_seq);
      check_field("ack_num", want.ack_num, got.ack_num);
      check_field("out_ref", want.out_ref, got.out_ref);
      check_field("out_len", want.out_len, got.out_len);
      check_field("last",    want.last,    got.last);
      check_field("closed",  want.closed,  got.closed);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  rrw_in_if  pkt_if ();
  rrw_out_if res_if ();
  rrw_cfg_if cfg_if ();

  reliable_receiver_reorder_window #(
    .WINDOW(WIN)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pkt_if),
    .out_o (res_if),
    .cfg_i (cfg_if)
  );

  reorder_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side back-pressure, with one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    rrw_pkg::out_item_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.kind    = res_if.kind;
      got.own_seq = res_if.own_seq;
      got.ack_num = res_if.ack_num;
      got.out_ref = res_if.out_ref;
      got.out_len = res_if.out_len;
      got.last    = res_if.last;
      got.closed  = res_if.closed;
      sb.check_result(got);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_isn(input logic [rrw_pkg::SEQ_W-1:0] v);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_isn(v);
  endtask

  task automatic offer_pkt(input logic [rrw_pkg::MODE_W-1:0] m,
                           input logic [rrw_pkg::SEQ_W-1:0] seq,
                           input logic [rrw_pkg::REF_W-1:0] pref,
                           input logic [rrw_pkg::LEN_W-1:0] plen);
    while ($urandom_range(99) < send_idle_pct) begin
      pkt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pkt_if.valid       <= 1'b1;
    pkt_if.mode        <= m;
    pkt_if.seq_num     <= seq;
    pkt_if.payload_ref <= pref;
    pkt_if.payload_len <= plen;
    do @(posedge clk_i); while (!pkt_if.ready);
    sb.take_packet(m, seq, pref, plen);
  endtask

  // packet at a given distance ahead of the expected sequence, random payload
  task automatic send_at(input logic [rrw_pkg::MODE_W-1:0] m,
                         input logic [rrw_pkg::SEQ_W-1:0] ahead);
    offer_pkt(m, sb.next_seq + ahead, rrw_pkg::REF_W'($urandom),
              rrw_pkg::LEN_W'($urandom));
  endtask

  task automatic send_random();
    int unsigned                 pick;
    logic [rrw_pkg::MODE_W-1:0]  m;
    logic [rrw_pkg::SEQ_W-1:0]   ahead;
    pick = $urandom_range(99);
    m    = rrw_pkg::MODE_DATA;
    if (pick < 30)      ahead = '0;
    else if (pick < 70) ahead = $urandom_range(WIN - 1, 1);
    else if (pick < 78) ahead = 32'h8000_0000 | $urandom;
    else if (pick < 85) ahead = 32'h0 - $urandom_range(20, 1);
    else if (pick < 92) ahead = $urandom_range(32'h7FFF_FFFF, WIN);
    else begin
      m     = pick[0] ? rrw_pkg::MODE_OTHER : rrw_pkg::MODE_CTRL;
      ahead = $urandom;
    end
    send_at(m, ahead);
  endtask

  task automatic run_random(input int quota);
    for (int i = 0; i < quota; i++) send_random();
  endtask

  // hold off until every pending result is in, then let the block settle
  task automatic wait_quiet();
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    rst_ni             <= 1'b0;
    pkt_if.valid       <= 1'b0;
    pkt_if.mode        <= rrw_pkg::MODE_OTHER;
    pkt_if.seq_num     <= '0;
    pkt_if.payload_ref <= '0;
    pkt_if.payload_len <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.data        <= '0;
    hold_req       = 1'b0;
    send_idle_pct  = 37;
    recv_idle_pct  = 86;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // both extremes while listening; the last one seeds own sequence, so it wraps
    write_isn(32'h0000_0000);
    write_isn(32'hFFFF_FFFF);
    cfg_if.valid <= 1'b0;

    // handshake: SYN-ACK ack wraps; expected sequence set just below the wrap
    offer_pkt(rrw_pkg::MODE_CTRL, 32'hFFFF_FFFF, 16'hFFFF, 12'hFFF);
    offer_pkt(rrw_pkg::MODE_OTHER, 32'hFFFF_FFF9, 16'h0000, 12'h000);

    offer_pkt(rrw_pkg::MODE_DATA, sb.next_seq, 16'hFFFF, 12'hFFF);
    offer_pkt(rrw_pkg::MODE_DATA, sb.next_seq + 1, 16'h0000, 12'h000);
    send_at(rrw_pkg::MODE_DATA, 1);                  // duplicate ahead, slot overwritten
    send_at(rrw_pkg::MODE_DATA, WIN - 1);            // far edge of window
    send_at(rrw_pkg::MODE_DATA, WIN);                // just beyond: dropped
    send_at(rrw_pkg::MODE_DATA, 32'h7FFF_FFFF);      // furthest beyond: dropped
    send_at(rrw_pkg::MODE_DATA, 32'h8000_0000);      // oldest stale
    send_at(rrw_pkg::MODE_DATA, 32'hFFFF_FFFF);      // just behind expected
    send_at(rrw_pkg::MODE_OTHER, 0);
    send_at(rrw_pkg::MODE_CTRL, 0);
    for (int i = 2; i < WIN - 1; i++) send_at(rrw_pkg::MODE_DATA, i);
    send_at(rrw_pkg::MODE_DATA, 0);                  // full window drain
    pkt_if.valid <= 1'b0;
    wait_quiet();
    write_isn($urandom);
    cfg_if.valid <= 1'b0;

    run_random(30);
    pkt_if.valid <= 1'b0;
    wait_quiet();
    write_isn(rrw_pkg::ISN_RESET);
    cfg_if.valid <= 1'b0;

    send_idle_pct = 86;
    recv_idle_pct = 37;
    run_random(30);
    pkt_if.valid <= 1'b0;
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req      = 1'b1;
    run_random(30);

    send_at(rrw_pkg::MODE_FIN, $urandom);
    // closed: both ignored
    send_at(rrw_pkg::MODE_DATA, 0);
    send_at(rrw_pkg::MODE_FIN, 0);
    pkt_if.valid <= 1'b0;
    wait_quiet();

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
